@@ rtl/kth_partition_into_n_parts_top_defines.svh @@
// Assertion macros for the fixed-count partition unranking block.
// Used by kth_partition_into_n_parts_top; relies on clk and rst_n in scope.
`ifndef KTH_PARTITION_INTO_N_PARTS_TOP_DEFINES_SVH
`define KTH_PARTITION_INTO_N_PARTS_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define KTHP_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define KTHP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KTHP_CHECK_SAME(label, ante, cons, msg)
`define KTHP_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/kthp_pkg.sv @@
// Shared types, constants and the microcode table of the partition unranking block.
// No dependencies; imported by kthp_seq, kthp_dp and the top level.
package kthp_pkg;

    localparam int MAX_PARTS = 16;
    localparam int SUM_WIDTH = 8;
    localparam int SUM_LIMIT = (SUM_WIDTH >= 8) ? 255 : ((1 << SUM_WIDTH) - 1);

    localparam int TOTAL_W = 8;
    localparam int PARTS_W = 5;
    localparam int IDX_W   = 32;
    localparam int DEPTH_W = $clog2(MAX_PARTS + 1);
    localparam int ADDR_W  = $clog2(MAX_PARTS);
    localparam int PROD_W  = TOTAL_W + DEPTH_W;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [PARTS_W-1:0] part_count;
        logic [IDX_W-1:0]   target_index;
    } kthp_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] part_value;
        logic               found;
        logic               last;
    } kthp_out_t;

    // Step codes of the microprogram
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHECK = 4'd1;
    localparam logic [STEP_W-1:0] ST_ENTER = 4'd2;
    localparam logic [STEP_W-1:0] ST_PUSH  = 4'd3;
    localparam logic [STEP_W-1:0] ST_LEAF  = 4'd4;
    localparam logic [STEP_W-1:0] ST_BACK  = 4'd5;
    localparam logic [STEP_W-1:0] ST_POP   = 4'd6;
    localparam logic [STEP_W-1:0] ST_EMIT  = 4'd7;
    localparam logic [STEP_W-1:0] ST_MISS  = 4'd8;

    // Branch conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_ALWAYS  = 3'd0;
    localparam logic [COND_W-1:0] C_START   = 3'd1;
    localparam logic [COND_W-1:0] C_BAD     = 3'd2;
    localparam logic [COND_W-1:0] C_LEAF    = 3'd3;
    localparam logic [COND_W-1:0] C_HIT     = 3'd4;
    localparam logic [COND_W-1:0] C_NEXT_OK = 3'd5;
    localparam logic [COND_W-1:0] C_ROOT    = 3'd6;
    localparam logic [COND_W-1:0] C_LAST    = 3'd7;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_HI      = 4'd2;
    localparam logic [OP_W-1:0] OP_PUSH    = 4'd3;
    localparam logic [OP_W-1:0] OP_DEC_IDX = 4'd4;
    localparam logic [OP_W-1:0] OP_HIT     = 4'd5;
    localparam logic [OP_W-1:0] OP_DEC_CUR = 4'd6;
    localparam logic [OP_W-1:0] OP_POP     = 4'd7;
    localparam logic [OP_W-1:0] OP_EMIT    = 4'd8;
    localparam logic [OP_W-1:0] OP_MISS    = 4'd9;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [OP_W-1:0]   op_t;
        logic [STEP_W-1:0] next_t;
        logic [OP_W-1:0]   op_f;
        logic [STEP_W-1:0] next_f;
    } ucode_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic bad;
        logic leaf;
        logic hit;
        logic next_ok;
        logic root;
        logic last;
    } kthp_stat_t;

    // Microprogram ROM: one control word per step
    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            ST_IDLE:  w = '{C_START,   OP_LOAD,    ST_CHECK, OP_NONE,    ST_IDLE};
            ST_CHECK: w = '{C_BAD,     OP_NONE,    ST_MISS,  OP_NONE,    ST_ENTER};
            ST_ENTER: w = '{C_LEAF,    OP_HI,      ST_LEAF,  OP_HI,      ST_PUSH};
            ST_PUSH:  w = '{C_ALWAYS,  OP_PUSH,    ST_ENTER, OP_PUSH,    ST_ENTER};
            ST_LEAF:  w = '{C_HIT,     OP_HIT,     ST_EMIT,  OP_DEC_IDX, ST_BACK};
            ST_BACK:  w = '{C_NEXT_OK, OP_DEC_CUR, ST_PUSH,  OP_NONE,    ST_POP};
            ST_POP:   w = '{C_ROOT,    OP_NONE,    ST_MISS,  OP_POP,     ST_BACK};
            ST_EMIT:  w = '{C_LAST,    OP_EMIT,    ST_IDLE,  OP_EMIT,    ST_EMIT};
            ST_MISS:  w = '{C_ALWAYS,  OP_MISS,    ST_IDLE,  OP_MISS,    ST_IDLE};
            default:  w = '{C_ALWAYS,  OP_NONE,    ST_IDLE,  OP_NONE,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/kthp_seq.sv @@
// Microcode sequencer: step counter, ROM lookup and conditional branch.
// Depends on kthp_pkg (ucode_word, step/condition/op codes, kthp_stat_t).
module kthp_seq
    import kthp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  kthp_stat_t        stat,
    output logic [OP_W-1:0]   op,
    output logic              busy
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              taken;

    assign word = ucode_word(step_reg);

    always_comb
    begin
        case (word.cond)
            C_ALWAYS:  taken = 1'b1;
            C_START:   taken = start;
            C_BAD:     taken = stat.bad;
            C_LEAF:    taken = stat.leaf;
            C_HIT:     taken = stat.hit;
            C_NEXT_OK: taken = stat.next_ok;
            C_ROOT:    taken = stat.root;
            C_LAST:    taken = stat.last;
            default:   taken = 1'b1;
        endcase
    end

    assign op        = taken ? word.op_t   : word.op_f;
    assign step_next = taken ? word.next_t : word.next_f;
    assign busy      = (step_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/kthp_dp.sv @@
// Search datapath: request registers, part stack, remainder and rank counters, result register.
// Depends on kthp_pkg (payload structs, op codes, widths).
module kthp_dp
    import kthp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [OP_W-1:0] op,
    input  kthp_in_t        request,
    output kthp_stat_t      stat,
    output kthp_out_t       result,
    output logic            strobe
);

    logic [TOTAL_W-1:0] total_reg;
    logic [PARTS_W-1:0] k_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [DEPTH_W-1:0] d_reg;
    logic [TOTAL_W-1:0] rem_reg;
    logic [TOTAL_W-1:0] cur_reg;
    logic [TOTAL_W-1:0] stack_reg [MAX_PARTS];
    kthp_out_t          result_reg;
    logic               strobe_reg;
    logic               strobe_next;

    logic [DEPTH_W-1:0] left;
    logic [DEPTH_W-1:0] left_m1;
    logic [DEPTH_W-1:0] d_m1;
    logic [TOTAL_W-1:0] cap;
    logic [TOTAL_W-1:0] hi;
    logic [TOTAL_W-1:0] dec_v;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  rd_addr;
    logic [TOTAL_W-1:0] rd_data;
    logic               at_last;

    // Parts still to place at this level, and the largest value that leaves one for each
    assign left    = DEPTH_W'(k_reg) - d_reg;
    assign left_m1 = left - DEPTH_W'(1);
    assign cap     = rem_reg - TOTAL_W'(left_m1);
    assign hi      = (cur_reg < cap) ? cur_reg : cap;

    // Next smaller candidate must still cover the remainder with left parts
    assign dec_v = cur_reg - TOTAL_W'(1);
    assign prod  = PROD_W'(dec_v) * PROD_W'(left);

    assign d_m1    = d_reg - DEPTH_W'(1);
    assign rd_addr = (op == OP_POP) ? d_m1[ADDR_W-1:0] : d_reg[ADDR_W-1:0];
    assign rd_data = stack_reg[rd_addr];
    assign at_last = (d_reg == (DEPTH_W'(k_reg) - DEPTH_W'(1)));

    always_comb
    begin
        stat.bad     = (k_reg == '0) || (int'(k_reg) > MAX_PARTS) || (total_reg == '0)
                       || (int'(total_reg) > SUM_LIMIT) || (TOTAL_W'(k_reg) > total_reg);
        stat.leaf    = (left == DEPTH_W'(1));
        stat.hit     = (idx_reg == '0);
        stat.next_ok = (cur_reg > TOTAL_W'(1)) && (prod >= PROD_W'(rem_reg));
        stat.root    = (d_reg == '0);
        stat.last    = at_last;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            case (op)
                OP_LOAD: d_reg <= '0;
                OP_PUSH: d_reg <= d_reg + DEPTH_W'(1);
                OP_HIT:  d_reg <= '0;
                OP_POP:  d_reg <= d_m1;
                OP_EMIT: d_reg <= d_reg + DEPTH_W'(1);
                default: d_reg <= d_reg;
            endcase
        end
    end

    assign strobe_next = (op == OP_EMIT) || (op == OP_MISS);

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                total_reg <= request.total;
                k_reg     <= request.part_count;
                idx_reg   <= request.target_index;
                rem_reg   <= request.total;
                cur_reg   <= request.total;
            end
            OP_HI:      cur_reg <= hi;
            OP_PUSH:
            begin
                stack_reg[d_reg[ADDR_W-1:0]] <= cur_reg;
                rem_reg <= rem_reg - cur_reg;
            end
            OP_DEC_IDX: idx_reg <= idx_reg - IDX_W'(1);
            OP_HIT:     stack_reg[d_reg[ADDR_W-1:0]] <= cur_reg;
            OP_DEC_CUR: cur_reg <= dec_v;
            OP_POP:
            begin
                cur_reg <= rd_data;
                rem_reg <= rem_reg + rd_data;
            end
            OP_EMIT:    result_reg <= '{part_value: rd_data, found: 1'b1, last: at_last};
            OP_MISS:    result_reg <= '{part_value: '0, found: 1'b0, last: 1'b1};
            default:    ;
        endcase
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

@@ rtl/kth_partition_into_n_parts_top.sv @@
// Timing: a bad request goes from the check step straight to the miss result; a rank-0 request
// of k parts walks enter and push steps down to its leaf, then emits its parts back to back.
// Every node the depth-first walk passes over on the way to the rank adds a parent back step,
// push, enter, leaf check, final back step and pop; the walk sets the time.
// Throughput: one transaction at a time; the next start is taken as the last result shows.
// Reset: rst_n (async, low) idles the sequencer and clears the strobe; no receiver stall.
`include "kth_partition_into_n_parts_top_defines.svh"
module kth_partition_into_n_parts_top
    import kthp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  kthp_in_t  request,
    output kthp_out_t result,
    output logic      strobe
);

    // The search walks partitions depth first, largest part first, with each
    // candidate bounded above by the part before it and by what the remaining
    // parts need, and below by what they can still cover. Every visited node
    // therefore leads to a partition, and each leaf counts the rank down.

    logic [OP_W-1:0] op;
    kthp_stat_t      stat;

    // Step counter and control ROM: pick one datapath operation per cycle
    kthp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    // Part stack, remainder, rank counter and result register
    kthp_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .request (request),
        .stat    (stat),
        .result  (result),
        .strobe  (strobe)
    );

    // An accepted transaction must take the sequencer out of idle
    `KTHP_CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left block idle")
    // Returning to idle always coincides with the final result of the transaction
    `KTHP_CHECK_SAME(a_idle_last, $fell(busy), strobe && result.last, "idle without final result")
    // A not-found result is a single zero item
    `KTHP_CHECK_SAME(a_miss_form, strobe && !result.found,
                     result.last && (result.part_value == '0), "malformed not-found result")
    // Nothing follows the final item right away
    `KTHP_CHECK_NEXT(a_last_gap, strobe && result.last, !strobe, "result after final item")

endmodule
